// File: rtl/polygon_coverage_expand_core_macros.svh
// Assertion macros shared by the polygon expand RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef POLYGON_COVERAGE_EXPAND_CORE_MACROS_SVH
`define POLYGON_COVERAGE_EXPAND_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define PCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("same-cycle check failed");
// next-cycle implication, disabled during reset
`define PCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");
`else
`define PCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/pce_pkg.sv
// Shared types and constants of the polygon expand block.
// No dependencies; used by the interfaces and all modules.
package pce_pkg;

	localparam int PCE_MAX_VERTICES = 10;
	localparam int POS_W   = 16;             // scaled position, 1/16 px
	localparam int SUM_W   = 20;             // position sums
	localparam int C_W     = 21;             // centroid, 1/256 px
	localparam int D_W     = 22;             // signed distance to centroid
	localparam int MAG_W   = 21;             // magnitude of distance
	localparam int AMT_W   = 8;              // push amount
	localparam int MUL_AW  = 43;             // multiplicand
	localparam int MUL_BW  = 30;             // multiplier, one bit per cycle
	localparam int MUL_PW  = 62;             // product / accumulator
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COORD_SCALE   = 3'd0,
		REG_USE_HIRES     = 3'd1,
		REG_MAX_X         = 3'd2,
		REG_MAX_Y         = 3'd3,
		REG_EXPAND_AMOUNT = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_LOAD, ST_CEN, ST_DIVX, ST_DIVY, ST_VTX, ST_LX, ST_LY,
		ST_MA, ST_SQ, ST_TRY, ST_CMP, ST_AXIS, ST_OUT
	} pce_state_t;

	// request to the shift-add multiplier
	typedef struct packed {
		logic              start;
		logic [MUL_AW-1:0] a;
		logic [MUL_BW-1:0] b;
		logic [MUL_PW-1:0] acc;
	} mul_req_t;

endpackage

// File: rtl/pce_if.sv
// Handshake channels of the polygon expand block: vertex in, result out, config.
// Depends on pce_pkg.
interface pce_vtx_if import pce_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    vertex_present;
	logic signed [POS_W-1:0] raw_x;
	logic signed [POS_W-1:0] raw_y;
	logic                    last_vertex;
	modport source (output valid, vertex_present, raw_x, raw_y, last_vertex, input ready);
	modport sink   (input valid, vertex_present, raw_x, raw_y, last_vertex, output ready);
endinterface

interface pce_res_if import pce_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] out_x;
	logic [POS_W-1:0] out_y;
	logic             out_last;
	modport source (output valid, out_x, out_y, out_last, input ready);
	modport sink   (input valid, out_x, out_y, out_last, output ready);
endinterface

interface pce_cfg_if import pce_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/pce_serial_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, with accumulate input.
// Depends on pce_pkg (mul_req_t and widths).
module pce_serial_mul import pce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mul_req_t          req,
	output logic              done,
	output logic [MUL_PW-1:0] prod
);
	logic              busy_q;
	logic [MUL_PW-1:0] a_q;
	logic [MUL_BW-1:0] b_q;
	logic [MUL_PW-1:0] p_q;

	// finished once the multiplier bits run out
	assign done = busy_q && (b_q == '0);
	assign prod = p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// datapath: add shifted multiplicand per set bit
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= MUL_PW'(req.a);
			b_q <= req.b;
			p_q <= req.acc;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) p_q <= p_q + a_q;
			a_q <= {a_q[MUL_PW-2:0], 1'b0};
			b_q <= {1'b0, b_q[MUL_BW-1:1]};
		end
	end
endmodule

// File: rtl/pce_serial_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pce_pkg (SUM_W sets the default numerator width).
module pce_serial_div import pce_pkg::*; #(
	parameter int NW = SUM_W + 5,
	parameter int DW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   sh;
	logic          fit;

	assign sh   = {rem_q, num_q[NW-1]};
	assign fit  = sh >= {1'b0, den_q};
	assign done = busy_q && (cnt_q == '0);
	assign quo  = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// numerator shifts out at the top, quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= fit ? DW'(sh - {1'b0, den_q}) : sh[DW-1:0];
			num_q <= {num_q[NW-2:0], fit};
		end
	end
endmodule

// File: rtl/polygon_coverage_expand_core.sv
// Top level of the polygon expand block: slot store, sequencer, config registers.
// Depends on pce_pkg, pce_if, pce_serial_mul, pce_serial_div and the macro header.
//
//  channel | modport | transfer carries
//  vtx     | sink    | vertex_present, raw_x, raw_y, last_vertex
//  res     | source  | out_x, out_y, out_last
//  cfg     | sink    | index, data (always ready)
//
// Vertices are taken while loading. In the cycle after the final vertex, the first of two
// centroid divides starts; the second follows it. With a nonzero amount, each present slot
// off the centroid then needs two squares, and per axis one product, one square and up to
// eight trial products on the shared shift-add multiplier; an absent slot goes straight to
// the output. Reset clears all control state; no vertex is taken while results drain.
`include "polygon_coverage_expand_core_macros.svh"

module polygon_coverage_expand_core import pce_pkg::*; #(
	parameter int MAX_VERTICES = PCE_MAX_VERTICES
) (
	input  logic  clk,
	input  logic  arst_n,
	pce_vtx_if.sink   vtx,
	pce_res_if.source res,
	pce_cfg_if.sink   cfg
);
	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int NUM_W = SUM_W + 5;

	// configuration
	logic [4:0]       coord_scale_q;
	logic             use_hires_q;
	logic [POS_W-1:0] max_x_q, max_y_q;
	logic [AMT_W-1:0] amount_q;

	// slot store
	logic [POS_W-1:0] slot_x_q [MAX_VERTICES];
	logic [POS_W-1:0] slot_y_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] slot_valid_q;
	logic [IDX_W-1:0] slot_idx_q, last_idx_q, k_q;
	logic [CNT_W-1:0] present_q;
	logic [SUM_W-1:0] sum_x_q, sum_y_q;

	// per-slot work
	pce_state_t state_q, state_d;
	logic [C_W-1:0]    cx_q, cy_q;
	logic [MUL_PW-1:0] len_q, rhs_q;
	logic [AMT_W-1:0]  lo_q;
	logic [2:0]        bit_q;
	logic              axis_q;
	logic signed [AMT_W:0] off_x_q;
	logic [POS_W-1:0]  out_x_q, out_y_q;
	logic              out_last_q;

	mul_req_t          mreq;
	logic              mdone;
	logic [MUL_PW-1:0] mprod;
	logic              dstart, ddone;
	logic [NUM_W-1:0]  dnum, dquo;

	logic vtx_xfer, res_xfer, is_final;
	logic [POS_W-1:0] scaled_x, scaled_y, cur_x, cur_y;
	logic signed [D_W-1:0] dx, dy, dsel;
	logic [MAG_W-1:0] mag_x, mag_y, mag_sel;
	logic active;
	logic [AMT_W-1:0] cand, lo_new;
	logic [8:0]       tval;
	logic signed [AMT_W:0] off_new;
	logic res_load;
	logic [POS_W-1:0] res_x, res_y;

	// scale a raw coordinate to 1/16 px, clamped to the position range
	function automatic logic [POS_W-1:0] scale_pos(input logic signed [POS_W-1:0] r,
			input logic hires, input logic [4:0] sc);
		logic [4:0] s;
		logic signed [POS_W+6:0] p;
		s = hires ? ((sc == 5'd0) ? 5'd1 : sc) : 5'd16;
		p = (POS_W+7)'(r) * $signed({2'b0, s});
		if (p < 0) scale_pos = '0;
		else if (p > $signed((POS_W+7)'(17'h0FFFF))) scale_pos = '1;
		else scale_pos = p[POS_W-1:0];
	endfunction

	// position plus signed offset, clamped to 0..hi
	function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] pos,
			input logic signed [AMT_W:0] off, input logic [POS_W-1:0] hi);
		logic signed [POS_W+1:0] v;
		v = $signed({2'b0, pos}) + (POS_W+2)'(off);
		if (v < 0) clamp_pos = '0;
		else if (v > $signed({2'b0, hi})) clamp_pos = hi;
		else clamp_pos = v[POS_W-1:0];
	endfunction

	pce_serial_mul u_mul (
		.clk(clk), .arst_n(arst_n), .req(mreq), .done(mdone), .prod(mprod)
	);

	pce_serial_div #(.NW(NUM_W), .DW(CNT_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum),
		.den(present_q), .done(ddone), .quo(dquo)
	);

	// handshakes
	assign vtx.ready = (state_q == ST_LOAD);
	assign vtx_xfer  = vtx.valid && vtx.ready;
	assign res.valid = (state_q == ST_OUT);
	assign res_xfer  = res.valid && res.ready;
	assign res.out_x = out_x_q;
	assign res.out_y = out_y_q;
	assign res.out_last = out_last_q;
	assign cfg.ready = 1'b1;

	assign is_final = vtx.last_vertex || (slot_idx_q == IDX_W'(MAX_VERTICES - 1));
	assign scaled_x = scale_pos(vtx.raw_x, use_hires_q, coord_scale_q);
	assign scaled_y = scale_pos(vtx.raw_y, use_hires_q, coord_scale_q);

	// distance of the current slot from the centroid
	assign cur_x = slot_x_q[k_q];
	assign cur_y = slot_y_q[k_q];
	assign dx = $signed({2'b0, cur_x, 4'b0}) - $signed({1'b0, cx_q});
	assign dy = $signed({2'b0, cur_y, 4'b0}) - $signed({1'b0, cy_q});
	assign mag_x = dx[D_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
	assign mag_y = dy[D_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
	assign mag_sel = axis_q ? mag_y : mag_x;
	assign dsel    = axis_q ? dy : dx;
	assign active  = slot_valid_q[k_q] && (amount_q != '0) && (present_q != '0);

	// bitwise search for the rounded offset
	assign cand   = lo_q | (AMT_W'(1) << bit_q);
	assign tval   = {cand, 1'b0} - 9'd1;
	assign lo_new = (mprod <= rhs_q) ? cand : lo_q;
	assign off_new = dsel[D_W-1] ? -$signed({1'b0, lo_q}) : $signed({1'b0, lo_q});

	// centroid numerators, taken once the final vertex is in the sums
	always_comb begin
		if (state_q == ST_CEN)
			dnum = {1'b0, sum_x_q, 4'b0} + NUM_W'(present_q >> 1);
		else
			dnum = {1'b0, sum_y_q, 4'b0} + NUM_W'(present_q >> 1);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: if (vtx_xfer && is_final) state_d = ST_CEN;
			ST_CEN:  state_d = ST_DIVX;
			ST_DIVX: if (ddone) state_d = ST_DIVY;
			ST_DIVY: if (ddone) state_d = ST_VTX;
			ST_VTX: begin
				if (!active || (dx == '0 && dy == '0)) state_d = ST_OUT;
				else state_d = ST_LX;
			end
			ST_LX: if (mdone) state_d = ST_LY;
			ST_LY: if (mdone) state_d = ST_MA;
			ST_MA: if (mdone) state_d = ST_SQ;
			ST_SQ: if (mdone) state_d = ST_TRY;
			ST_TRY: begin
				if (cand > amount_q) state_d = (bit_q == '0) ? ST_AXIS : ST_TRY;
				else state_d = ST_CMP;
			end
			ST_CMP: if (mdone) state_d = (bit_q == '0) ? ST_AXIS : ST_TRY;
			ST_AXIS: state_d = axis_q ? ST_OUT : ST_MA;
			ST_OUT: begin
				if (res_xfer) state_d = (k_q == last_idx_q) ? ST_LOAD : ST_VTX;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// unit requests and result selection
	always_comb begin
		mreq     = '0;
		dstart   = 1'b0;
		res_load = 1'b0;
		res_x    = '0;
		res_y    = '0;
		case (state_q)
			ST_CEN:  dstart = 1'b1;
			ST_DIVX: dstart = ddone;
			ST_VTX: begin
				if (!active) begin
					res_load = 1'b1;
				end else if (dx == '0 && dy == '0) begin
					res_load = 1'b1;
					res_x = clamp_pos(cur_x, '0, max_x_q);
					res_y = clamp_pos(cur_y, '0, max_y_q);
				end else begin
					mreq.start = 1'b1;
					mreq.a = MUL_AW'(mag_x);
					mreq.b = MUL_BW'(mag_x);
				end
			end
			ST_LX: begin
				mreq.start = mdone;
				mreq.a   = MUL_AW'(mag_y);
				mreq.b   = MUL_BW'(mag_y);
				mreq.acc = mprod;
			end
			ST_LY: begin
				mreq.start = mdone;
				mreq.a = MUL_AW'({mag_x, 1'b0});
				mreq.b = MUL_BW'(amount_q);
			end
			ST_MA: begin
				mreq.start = mdone;
				mreq.a = MUL_AW'(mprod[MUL_BW-1:0]);
				mreq.b = mprod[MUL_BW-1:0];
			end
			ST_TRY: begin
				mreq.start = (cand <= amount_q);
				mreq.a = len_q[MUL_AW-1:0];
				mreq.b = MUL_BW'(tval * tval);
			end
			ST_AXIS: begin
				if (!axis_q) begin
					mreq.start = 1'b1;
					mreq.a = MUL_AW'({mag_y, 1'b0});
					mreq.b = MUL_BW'(amount_q);
				end else begin
					res_load = 1'b1;
					res_x = clamp_pos(cur_x, off_x_q, max_x_q);
					res_y = clamp_pos(cur_y, off_new, max_y_q);
				end
			end
			default: ;
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_scale_q <= 5'd1;
			use_hires_q   <= 1'b0;
			max_x_q       <= 16'd4095;
			max_y_q       <= 16'd3071;
			amount_q      <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_COORD_SCALE:   coord_scale_q <= cfg.data[4:0];
				REG_USE_HIRES:     use_hires_q   <= cfg.data[0];
				REG_MAX_X:         max_x_q       <= cfg.data;
				REG_MAX_Y:         max_y_q       <= cfg.data;
				REG_EXPAND_AMOUNT: amount_q      <= cfg.data[AMT_W-1:0];
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			slot_valid_q <= '0;
			slot_idx_q   <= '0;
			last_idx_q   <= '0;
			present_q    <= '0;
			sum_x_q      <= '0;
			sum_y_q      <= '0;
			k_q          <= '0;
			lo_q         <= '0;
			bit_q        <= '0;
			axis_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (vtx_xfer) begin
				slot_valid_q[slot_idx_q] <= vtx.vertex_present;
				if (vtx.vertex_present) begin
					present_q <= present_q + 1'b1;
					sum_x_q   <= sum_x_q + SUM_W'(scaled_x);
					sum_y_q   <= sum_y_q + SUM_W'(scaled_y);
				end
				slot_idx_q <= is_final ? '0 : slot_idx_q + 1'b1;
				last_idx_q <= slot_idx_q;
				k_q        <= '0;
			end
			case (state_q)
				ST_VTX:  axis_q <= 1'b0;
				ST_SQ: begin
					lo_q  <= '0;
					bit_q <= 3'd7;
				end
				ST_TRY: if (cand > amount_q && bit_q != '0) bit_q <= bit_q - 1'b1;
				ST_CMP: begin
					if (mdone) begin
						lo_q <= lo_new;
						if (bit_q != '0) bit_q <= bit_q - 1'b1;
					end
				end
				ST_AXIS: axis_q <= 1'b1;
				ST_OUT: begin
					if (res_xfer) begin
						if (k_q == last_idx_q) begin
							slot_valid_q <= '0;
							present_q    <= '0;
							sum_x_q      <= '0;
							sum_y_q      <= '0;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (vtx_xfer) begin
			slot_x_q[slot_idx_q] <= vtx.vertex_present ? scaled_x : '0;
			slot_y_q[slot_idx_q] <= vtx.vertex_present ? scaled_y : '0;
		end
		if (state_q == ST_DIVX && ddone) cx_q <= dquo[C_W-1:0];
		if (state_q == ST_DIVY && ddone) cy_q <= dquo[C_W-1:0];
		if (state_q == ST_LY && mdone) len_q <= mprod;
		if (state_q == ST_SQ && mdone) rhs_q <= mprod;
		if (state_q == ST_AXIS && !axis_q) off_x_q <= off_new;
		if (res_load) begin
			out_x_q    <= res_x;
			out_y_q    <= res_y;
			out_last_q <= (k_q == last_idx_q);
		end
	end

	// checks
	`PCE_ASSERT_IMP(ap_no_overlap, clk, arst_n, vtx.ready, !res.valid)
	`PCE_ASSERT_NXT(ap_last_reload, clk, arst_n, res_xfer && res.out_last, vtx.ready)
	`PCE_ASSERT_IMP(ap_lo_bound, clk, arst_n, state_q == ST_TRY || state_q == ST_CMP, lo_q <= amount_q)

endmodule
